// ----- src/ml_tok_pkg.sv -----
// ml_tok_pkg: token kinds, error codes, result beat types and keyword text
// for the ml token lexer. No dependencies.
package ml_tok_pkg;

   localparam int RSP_W  = 144;
   localparam int Q_DEPTH = 8;
   localparam int Q_AW   = 3;

   localparam logic [5:0] K_EOF    = 6'd0;
   localparam logic [5:0] K_INT    = 6'd1;
   localparam logic [5:0] K_FLOAT  = 6'd2;
   localparam logic [5:0] K_IDENT  = 6'd3;
   localparam logic [5:0] K_LET    = 6'd4;
   localparam logic [5:0] K_REC    = 6'd5;
   localparam logic [5:0] K_IN     = 6'd6;
   localparam logic [5:0] K_IF     = 6'd7;
   localparam logic [5:0] K_THEN   = 6'd8;
   localparam logic [5:0] K_ELSE   = 6'd9;
   localparam logic [5:0] K_TRUE   = 6'd10;
   localparam logic [5:0] K_FALSE  = 6'd11;
   localparam logic [5:0] K_NOT    = 6'd12;
   localparam logic [5:0] K_ARRAY  = 6'd13;
   localparam logic [5:0] K_PLUS   = 6'd14;
   localparam logic [5:0] K_MINUS  = 6'd15;
   localparam logic [5:0] K_FPLUS  = 6'd16;
   localparam logic [5:0] K_FMINUS = 6'd17;
   localparam logic [5:0] K_FSTAR  = 6'd18;
   localparam logic [5:0] K_FSLASH = 6'd19;
   localparam logic [5:0] K_EQ     = 6'd20;
   localparam logic [5:0] K_LT     = 6'd21;
   localparam logic [5:0] K_GT     = 6'd22;
   localparam logic [5:0] K_LE     = 6'd23;
   localparam logic [5:0] K_GE     = 6'd24;
   localparam logic [5:0] K_NEQ    = 6'd25;
   localparam logic [5:0] K_LPAREN = 6'd26;
   localparam logic [5:0] K_RPAREN = 6'd27;
   localparam logic [5:0] K_COMMA  = 6'd28;
   localparam logic [5:0] K_SEMI   = 6'd29;
   localparam logic [5:0] K_DOT    = 6'd30;
   localparam logic [5:0] K_LARROW = 6'd31;
   localparam logic [5:0] K_ERROR  = 6'd32;

   localparam logic [2:0] E_NONE  = 3'd0;
   localparam logic [2:0] E_STAR  = 3'd1;
   localparam logic [2:0] E_SLASH = 3'd2;
   localparam logic [2:0] E_BYTE  = 3'd3;
   localparam logic [2:0] E_LONG  = 3'd4;

   localparam logic [39:0] W_LET   = 40'("let");
   localparam logic [39:0] W_REC   = 40'("rec");
   localparam logic [39:0] W_IN    = 40'("in");
   localparam logic [39:0] W_IF    = 40'("if");
   localparam logic [39:0] W_THEN  = 40'("then");
   localparam logic [39:0] W_ELSE  = 40'("else");
   localparam logic [39:0] W_TRUE  = 40'("true");
   localparam logic [39:0] W_FALSE = 40'("false");
   localparam logic [39:0] W_NOT   = 40'("not");
   localparam logic [39:0] W_ARRAY = 40'("Array");

   typedef struct packed {
      logic [2:0]  error_code;
      logic [62:0] int_value;
      logic [7:0]  token_length;
      logic [31:0] token_start;
      logic [5:0]  token_kind;
   } res_type;

   typedef struct packed {
      logic [2:0]        cnt;
      logic [31:0]       line;
      res_type [3:0]     ent;
   } push_type;

   typedef struct packed {
      logic        last;
      logic [31:0] line;
      res_type     res;
   } qent_type;

   function automatic res_type mk_res(input logic [5:0] kind, input logic [31:0] start,
                                      input logic [7:0] len, input logic [62:0] val,
                                      input logic [2:0] err);
      res_type r;
      r.token_kind   = kind;
      r.token_start  = start;
      r.token_length = len;
      r.int_value    = val;
      r.error_code   = err;
      return r;
   endfunction

   // prefix of "create" or "make" of k bytes, packed
   function automatic logic [39:0] word_prefix(input logic is_make, input logic [2:0] k);
      logic [39:0] w;
      w = '0;
      if (is_make) begin
         unique case (k)
            3'd1:    w = 40'("m");
            3'd2:    w = 40'("ma");
            3'd3:    w = 40'("mak");
            default: w = 40'("m");
         endcase
      end else begin
         unique case (k)
            3'd1:    w = 40'("c");
            3'd2:    w = 40'("cr");
            3'd3:    w = 40'("cre");
            3'd4:    w = 40'("crea");
            3'd5:    w = 40'("creat");
            default: w = 40'("c");
         endcase
      end
      return w;
   endfunction

   // byte k of "create" or "make"
   function automatic logic [7:0] word_char(input logic is_make, input logic [2:0] k);
      logic [7:0] c;
      c = "r";
      if (is_make) begin
         unique case (k)
            3'd1:    c = "a";
            3'd2:    c = "k";
            3'd3:    c = "e";
            default: c = "a";
         endcase
      end else begin
         unique case (k)
            3'd1:    c = "r";
            3'd2:    c = "e";
            3'd3:    c = "a";
            3'd4:    c = "t";
            3'd5:    c = "e";
            default: c = "r";
         endcase
      end
      return c;
   endfunction

endpackage

// ----- src/ml_token_lexer_unit.sv -----
// ml_token_lexer_unit: top level of the ml token lexer, scanner core plus
// result queue. Depends on ml_tok_pkg, ml_tok_core and ml_tok_fifo.
//
// Usage:
//   req channel carries one source byte per beat; byte 0 ends the text.
//   rsp channel carries one token per beat; rsp_tlast marks the final token
//   caused by a given source byte. A byte may cause zero to four tokens.
//   The scanner updates its state in the same cycle a byte is taken and
//   writes the tokens into an eight-entry queue, so a token shows on rsp
//   from that registered queue once the tokens ahead of it have left.
//   Throughput is one byte per cycle; req_tready stays high while the
//   queue holds four tokens or fewer, so one token-producing byte per cycle
//   streams through without a gap and the queue size sets the slack.
//   When rsp_tready is low the queue fills and req_tready drops until
//   there is room for four more tokens.
//   After an error token or the end-of-text token the block takes bytes
//   but emits nothing until reset.
//   reset is synchronous and active high: line count 1, offset 0, queue
//   empty, scanner between tokens.
module ml_token_lexer_unit #(
   parameter int MAX_LEXEME = 256,
   parameter int DEPTH_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // text_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // token_kind, token_start, token_length, token_line, int_value, error_code
   output logic [ml_tok_pkg::RSP_W-1:0] rsp_tdata,
   output logic                         rsp_tlast    // last_of_run
);
   import ml_tok_pkg::*;

   push_type push;
   qent_type ent;
   logic     room;

   ml_tok_core #(
      .MAX_LEXEME(MAX_LEXEME),
      .DEPTH_BITS(DEPTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_tvalid && req_tready),
      .text_byte  (req_tdata),
      .push       (push)
   );

   ml_tok_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_ent   (ent)
   );

   assign req_tready = room;
   assign rsp_tdata  = {ent.res.error_code, ent.res.int_value, ent.line,
                        ent.res.token_length, ent.res.token_start, ent.res.token_kind};
   assign rsp_tlast  = ent.last;

endmodule

// ----- src/ml_tok_core.sv -----
// ml_tok_core: scanner state and the per-beat transition that turns one
// source byte into up to four tokens. Depends on ml_tok_pkg.
module ml_tok_core #(
   parameter int MAX_LEXEME = 256,
   parameter int DEPTH_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_valid,
   input  logic [7:0]         text_byte,
   output ml_tok_pkg::push_type push
);
   import ml_tok_pkg::*;

   localparam int LW = $clog2(MAX_LEXEME + 3);
   localparam logic [LW-1:0] LEN_CAP = LW'(MAX_LEXEME + 2);
   localparam logic [LW-1:0] LEN_MAX = LW'(MAX_LEXEME);
   localparam logic [DEPTH_BITS-1:0] DEPTH_TOP = '1;

   typedef enum logic [4:0] {
      M_IDLE, M_DONE, M_LPAREN, M_COMMENT, M_CSTAR, M_CLPAREN,
      M_PLUS, M_MINUS, M_STAR, M_SLASH, M_LT, M_GT,
      M_INT, M_FRAC, M_EXP, M_INT_E, M_FLT_E, M_INT_ES, M_FLT_ES,
      M_IDENT, M_ARR_DOT, M_ARR_C, M_ARR_M
   } mode_type;

   typedef struct packed {
      mode_type              mode;
      logic [DEPTH_BITS-1:0] depth;
      logic [31:0]           start;
      logic [LW-1:0]         len;
      logic [62:0]           acc;
      logic [39:0]           prefix;
      logic                  halted;
   } state_type;

   typedef struct packed {
      state_type     st;
      logic [1:0]    n;
      res_type [1:0] r;
      logic          again;
      logic          line_inc;
   } step_type;

   state_type   state_ff, state_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] line_ff, line_in;

   logic [66:0] acc10;
   logic [62:0] acc_dig;
   step_type    h1, h2, h3;
   logic        active, run2, run3;
   res_type [3:0] lst;
   logic [2:0]  cnt;

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_idc(input logic [7:0] b);
      return is_alpha(b) || is_digit(b) || b == "_" || b == "'";
   endfunction

   function automatic logic [7:0] sat8(input logic [LW-1:0] v);
      return (32'(v) > 32'd255) ? 8'hff : 8'(v);
   endfunction

   function automatic logic [LW-1:0] grow(input logic [LW-1:0] v);
      return (v < LEN_CAP) ? v + LW'(1) : v;
   endfunction

   function automatic logic [5:0] classify(input logic [LW-1:0] len, input logic [39:0] p);
      logic [31:0] l;
      logic [5:0]  k;
      l = 32'(len);
      k = K_IDENT;
      priority if (l == 32'd3 && p == W_LET)   k = K_LET;
      else if (l == 32'd3 && p == W_REC)   k = K_REC;
      else if (l == 32'd2 && p == W_IN)    k = K_IN;
      else if (l == 32'd2 && p == W_IF)    k = K_IF;
      else if (l == 32'd4 && p == W_THEN)  k = K_THEN;
      else if (l == 32'd4 && p == W_ELSE)  k = K_ELSE;
      else if (l == 32'd4 && p == W_TRUE)  k = K_TRUE;
      else if (l == 32'd5 && p == W_FALSE) k = K_FALSE;
      else if (l == 32'd3 && p == W_NOT)   k = K_NOT;
      else k = K_IDENT;
      return k;
   endfunction

   // int or float end: too long gives an error instead
   function automatic step_type emit_lex(input step_type o, input logic [5:0] kind,
                                         input logic [31:0] s, input logic [LW-1:0] len,
                                         input logic [62:0] val);
      step_type q;
      q = o;
      q.n = 2'd1;
      if (len >= LEN_MAX) begin
         q.r[0] = mk_res(K_ERROR, s, 8'hff, '0, E_LONG);
         q.st.halted = 1'b1;
         q.again = 1'b0;
      end else begin
         q.r[0] = mk_res(kind, s, sat8(len), '0, E_NONE);
         q.r[0].int_value = val;
         q.again = 1'b1;
      end
      return q;
   endfunction

   function automatic step_type handle(input state_type s, input logic [7:0] b,
                                       input logic [31:0] pos, input logic [62:0] adig);
      step_type      o;
      logic          isint;
      logic [5:0]    nk;
      logic [62:0]   nv;
      logic [LW-1:0] ml;
      logic [31:0]   es;
      logic [LW-1:0] kr;
      logic [2:0]    kk;
      logic          mk;
      logic [2:0]    wl;
      o = '0;
      o.st = s;
      isint = s.mode == M_INT_E || s.mode == M_INT_ES;
      nk = isint ? K_INT : K_FLOAT;
      nv = isint ? s.acc : '0;
      ml = '0;
      es = '0;
      mk = s.mode == M_ARR_M;
      wl = mk ? 3'd4 : 3'd6;
      kr = s.len - LW'(6);
      kk = (kr < LW'(1) || 32'(kr) >= 32'(wl)) ? 3'd1 : kr[2:0];
      unique case (s.mode)
         M_IDLE: begin
            if (b == 8'd0) begin
               o.r[0] = mk_res(K_EOF, pos, 8'd0, '0, E_NONE);
               o.n = 2'd1;
               o.st.mode = M_DONE;
            end else if (b == 8'h0a) begin
               o.line_inc = 1'b1;
            end else if (b == " " || b == 8'h09 || b == 8'h0d) begin
               o.st.mode = M_IDLE;
            end else begin
               o.st.start = pos;
               o.st.len = LW'(1);
               if (is_digit(b)) begin
                  o.st.mode = M_INT;
                  o.st.acc = 63'(b[3:0]);
               end else if (is_alpha(b) || b == "_") begin
                  o.st.mode = M_IDENT;
                  o.st.prefix = 40'(b);
               end else begin
                  o.n = 2'd1;
                  o.r[0] = mk_res(K_EQ, pos, 8'd1, '0, E_NONE);
                  unique case (b)
                     "(": begin o.st.mode = M_LPAREN; o.n = 2'd0; end
                     "+": begin o.st.mode = M_PLUS; o.n = 2'd0; end
                     "-": begin o.st.mode = M_MINUS; o.n = 2'd0; end
                     "*": begin o.st.mode = M_STAR; o.n = 2'd0; end
                     "/": begin o.st.mode = M_SLASH; o.n = 2'd0; end
                     "<": begin o.st.mode = M_LT; o.n = 2'd0; end
                     ">": begin o.st.mode = M_GT; o.n = 2'd0; end
                     "=": o.r[0].token_kind = K_EQ;
                     ")": o.r[0].token_kind = K_RPAREN;
                     ",": o.r[0].token_kind = K_COMMA;
                     ";": o.r[0].token_kind = K_SEMI;
                     ".": o.r[0].token_kind = K_DOT;
                     default: begin
                        o.r[0] = mk_res(K_ERROR, pos, 8'd1, '0, E_BYTE);
                        o.st.halted = 1'b1;
                     end
                  endcase
               end
            end
         end
         M_LPAREN: begin
            if (b == "*") begin
               o.st.mode = M_COMMENT;
               o.st.depth = DEPTH_BITS'(1);
            end else begin
               o.r[0] = mk_res(K_LPAREN, s.start, 8'd1, '0, E_NONE);
               o.n = 2'd1;
               o.st.mode = M_IDLE;
               o.again = 1'b1;
            end
         end
         M_COMMENT, M_CSTAR, M_CLPAREN: begin
            if (b == 8'd0) begin
               o.r[0] = mk_res(K_EOF, pos, 8'd0, '0, E_NONE);
               o.n = 2'd1;
               o.st.mode = M_DONE;
            end else begin
               o.line_inc = b == 8'h0a;
               priority if (s.mode == M_CLPAREN && b == "*") begin
                  if (s.depth < DEPTH_TOP) o.st.depth = s.depth + DEPTH_BITS'(1);
                  o.st.mode = M_COMMENT;
               end else if (s.mode == M_CSTAR && b == ")") begin
                  if (s.depth > '0) o.st.depth = s.depth - DEPTH_BITS'(1);
                  o.st.mode = (s.depth <= DEPTH_BITS'(1)) ? M_IDLE : M_COMMENT;
               end else if (b == "(") begin
                  o.st.mode = M_CLPAREN;
               end else if (b == "*") begin
                  o.st.mode = M_CSTAR;
               end else begin
                  o.st.mode = M_COMMENT;
               end
            end
         end
         M_PLUS, M_MINUS: begin
            o.n = 2'd1;
            o.st.mode = M_IDLE;
            if (b == ".") begin
               o.r[0] = mk_res((s.mode == M_PLUS) ? K_FPLUS : K_FMINUS, s.start, 8'd2,
                               '0, E_NONE);
            end else begin
               o.r[0] = mk_res((s.mode == M_PLUS) ? K_PLUS : K_MINUS, s.start, 8'd1,
                               '0, E_NONE);
               o.again = 1'b1;
            end
         end
         M_STAR, M_SLASH: begin
            o.n = 2'd1;
            if (b == ".") begin
               o.r[0] = mk_res((s.mode == M_STAR) ? K_FSTAR : K_FSLASH, s.start, 8'd2,
                               '0, E_NONE);
               o.st.mode = M_IDLE;
            end else begin
               o.r[0] = mk_res(K_ERROR, s.start, 8'd1, '0,
                               (s.mode == M_STAR) ? E_STAR : E_SLASH);
               o.st.halted = 1'b1;
            end
         end
         M_LT: begin
            o.n = 2'd1;
            o.st.mode = M_IDLE;
            o.r[0] = mk_res(K_LT, s.start, 8'd2, '0, E_NONE);
            priority if (b == "=") o.r[0].token_kind = K_LE;
            else if (b == ">") o.r[0].token_kind = K_NEQ;
            else if (b == "-") o.r[0].token_kind = K_LARROW;
            else begin
               o.r[0].token_length = 8'd1;
               o.again = 1'b1;
            end
         end
         M_GT: begin
            o.n = 2'd1;
            o.st.mode = M_IDLE;
            o.r[0] = mk_res(K_GE, s.start, 8'd2, '0, E_NONE);
            if (b != "=") begin
               o.r[0].token_kind = K_GT;
               o.r[0].token_length = 8'd1;
               o.again = 1'b1;
            end
         end
         M_INT: begin
            if (is_digit(b)) begin
               o.st.acc = adig;
               o.st.len = grow(s.len);
            end else if (b == ".") begin
               o.st.mode = M_FRAC;
               o.st.len = grow(s.len);
            end else if (b == "e" || b == "E") begin
               o.st.mode = M_INT_E;
               o.st.prefix = 40'(b);
               o.st.len = grow(s.len);
            end else begin
               o.st.mode = M_IDLE;
               o = emit_lex(o, K_INT, s.start, s.len, s.acc);
            end
         end
         M_FRAC, M_EXP: begin
            if (is_digit(b)) begin
               o.st.len = grow(s.len);
            end else if (s.mode == M_FRAC && (b == "e" || b == "E")) begin
               o.st.mode = M_FLT_E;
               o.st.prefix = 40'(b);
               o.st.len = grow(s.len);
            end else begin
               o.st.mode = M_IDLE;
               o = emit_lex(o, K_FLOAT, s.start, s.len, '0);
            end
         end
         M_INT_E, M_FLT_E: begin
            if (is_digit(b)) begin
               o.st.mode = M_EXP;
               o.st.len = grow(s.len);
            end else if (b == "+" || b == "-") begin
               o.st.mode = isint ? M_INT_ES : M_FLT_ES;
               o.st.prefix = {24'd0, b, s.prefix[7:0]};
               o.st.len = grow(s.len);
            end else begin
               ml = s.len - LW'(1);
               es = s.start + 32'(ml);
               o = emit_lex(o, nk, s.start, ml, nv);
               if (!o.st.halted) begin
                  o.st.mode = M_IDENT;
                  o.st.start = es;
                  o.st.len = LW'(1);
                  o.st.prefix = {32'd0, s.prefix[7:0]};
               end
            end
         end
         M_INT_ES, M_FLT_ES: begin
            if (is_digit(b)) begin
               o.st.mode = M_EXP;
               o.st.len = grow(s.len);
            end else begin
               ml = s.len - LW'(2);
               es = s.start + 32'(ml);
               o = emit_lex(o, nk, s.start, ml, nv);
               if (!o.st.halted) begin
                  o.r[1] = mk_res(K_IDENT, es, 8'd1, '0, E_NONE);
                  o.n = 2'd2;
                  o.st.mode = (s.prefix[15:8] == "+") ? M_PLUS : M_MINUS;
                  o.st.start = es + 32'd1;
                  o.st.len = LW'(1);
               end
            end
         end
         M_IDENT: begin
            if (is_idc(b)) begin
               if (s.len < LW'(5)) o.st.prefix = {s.prefix[31:0], b};
               o.st.len = grow(s.len);
            end else if (s.len >= LEN_MAX) begin
               o.r[0] = mk_res(K_ERROR, s.start, 8'hff, '0, E_LONG);
               o.n = 2'd1;
               o.st.halted = 1'b1;
            end else if (s.len == LW'(5) && b == "." && s.prefix == W_ARRAY) begin
               o.st.mode = M_ARR_DOT;
               o.st.len = grow(s.len);
            end else begin
               o.r[0] = mk_res(classify(s.len, s.prefix), s.start, sat8(s.len), '0, E_NONE);
               o.n = 2'd1;
               o.st.mode = M_IDLE;
               o.again = 1'b1;
            end
         end
         M_ARR_DOT: begin
            if (b == "c") begin
               o.st.mode = M_ARR_C;
               o.st.len = grow(s.len);
            end else if (b == "m") begin
               o.st.mode = M_ARR_M;
               o.st.len = grow(s.len);
            end else begin
               o.r[0] = mk_res(K_IDENT, s.start, 8'd5, '0, E_NONE);
               o.r[1] = mk_res(K_DOT, s.start + 32'd5, 8'd1, '0, E_NONE);
               o.n = 2'd2;
               o.st.mode = M_IDLE;
               o.again = 1'b1;
            end
         end
         M_ARR_C, M_ARR_M: begin
            if (b == word_char(mk, kk)) begin
               o.st.len = grow(s.len);
               if (kk + 3'd1 == wl) begin
                  o.r[0] = mk_res(K_ARRAY, s.start, 8'd6 + 8'(wl), '0, E_NONE);
                  o.n = 2'd1;
                  o.st.mode = M_IDLE;
               end
            end else begin
               o.r[0] = mk_res(K_IDENT, s.start, 8'd5, '0, E_NONE);
               o.r[1] = mk_res(K_DOT, s.start + 32'd5, 8'd1, '0, E_NONE);
               o.n = 2'd2;
               o.st.start = s.start + 32'd6;
               o.st.len = LW'(kk);
               o.st.prefix = word_prefix(mk, kk);
               o.st.mode = M_IDENT;
               o.again = 1'b1;
            end
         end
         default: o.st = s;
      endcase
      return o;
   endfunction

   always_comb begin
      acc10 = ({4'd0, state_ff.acc} << 3) + ({4'd0, state_ff.acc} << 1) + 67'(text_byte[3:0]);
      acc_dig = (|acc10[66:63]) ? '1 : acc10[62:0];

      active = !state_ff.halted && state_ff.mode != M_DONE;
      h1 = handle(state_ff, text_byte, offset_ff, acc_dig);
      run2 = active && h1.again;
      h2 = handle(h1.st, text_byte, offset_ff, acc_dig);
      run3 = run2 && h2.again;
      h3 = handle(h2.st, text_byte, offset_ff, acc_dig);

      lst = '0;
      cnt = '0;
      if (active) begin
         for (int j = 0; j < 2; j++) begin
            if (2'(j) < h1.n && cnt < 3'd4) begin
               lst[cnt[1:0]] = h1.r[j];
               cnt = cnt + 3'd1;
            end
         end
      end
      if (run2) begin
         for (int j = 0; j < 2; j++) begin
            if (2'(j) < h2.n && cnt < 3'd4) begin
               lst[cnt[1:0]] = h2.r[j];
               cnt = cnt + 3'd1;
            end
         end
      end
      if (run3) begin
         for (int j = 0; j < 2; j++) begin
            if (2'(j) < h3.n && cnt < 3'd4) begin
               lst[cnt[1:0]] = h3.r[j];
               cnt = cnt + 3'd1;
            end
         end
      end

      state_in = state_ff;
      line_in = line_ff;
      offset_in = offset_ff;
      if (byte_valid) begin
         offset_in = offset_ff + 32'd1;
         if (active) begin
            state_in = run3 ? h3.st : (run2 ? h2.st : h1.st);
            if ((h1.line_inc || (run2 && h2.line_inc) || (run3 && h3.line_inc))
                && line_ff != '1)
               line_in = line_ff + 32'd1;
         end
      end

      push.cnt = byte_valid ? cnt : 3'd0;
      push.line = line_ff;
      push.ent = lst;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{mode: M_IDLE, depth: '0, start: '0, len: '0, acc: '0,
                       prefix: '0, halted: 1'b0};
         offset_ff <= '0;
         line_ff <= 32'd1;
      end else begin
         state_ff <= state_in;
         offset_ff <= offset_in;
         line_ff <= line_in;
      end
   end

endmodule

// ----- src/ml_tok_fifo.sv -----
// ml_tok_fifo: eight-entry result queue that takes up to four tokens per
// beat and hands them out one per beat. Depends on ml_tok_pkg.
module ml_tok_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  ml_tok_pkg::push_type push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ml_tok_pkg::qent_type out_ent
);
   import ml_tok_pkg::*;

   qent_type        mem_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ff, wr_in;
   logic [Q_AW-1:0] rd_ff, rd_in;
   logic [Q_AW:0]   count_ff, count_in;
   logic            pop;

   assign room      = count_ff <= (Q_AW+1)'(Q_DEPTH - 4);
   assign out_valid = count_ff != '0;
   assign out_ent   = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff + Q_AW'(push.cnt);
      rd_in    = pop ? rd_ff + Q_AW'(1) : rd_ff;
      count_in = count_ff + (Q_AW+1)'(push.cnt) - (Q_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < push.cnt) begin
            mem_ff[wr_ff + Q_AW'(i)] <= '{last: 3'(i) == push.cnt - 3'd1,
                                          line: push.line, res: push.ent[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule
